// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must never be true outside reset.
`define BB3_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define BB3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bb3_pkg.sv -----
`timescale 1ns / 1ps

package bb3_pkg;

    // Line memory ring: eight rows, so the front can run ahead of the back.
    localparam int SLOT_BITS = 3;

    // Configuration register width and reset sizes
    localparam int CFG_BITS             = 11;
    localparam int FRAME_WIDTH_DEFAULT  = 640;
    localparam int FRAME_HEIGHT_DEFAULT = 480;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef logic [SLOT_BITS-1:0] slot_t;

    // Red sits in the lowest byte, matching tdata.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Which neighbors of a result pixel lie inside the frame, and whether it ends the frame
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } job_flags_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_DRAIN,
        BK_FINISH
    } back_state_t;

endpackage

// ----- rtl/bb3_queue.sv -----
`timescale 1ns / 1ps

module bb3_queue #(
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);
    import bb3_pkg::*;

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/bb3_front.sv -----
`timescale 1ns / 1ps

module bb3_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    input  bb3_pkg::pixel_t                                s_axis_tdata,
    input  logic                                           s_axis_tuser,
    input  logic                                           cfg_we,
    input  logic                                           cfg_index,
    input  logic [bb3_pkg::CFG_BITS-1:0]                   cfg_data,
    input  logic                                           queue_full,
    output logic                                           job_push,
    output bb3_pkg::job_flags_t                            job_flags,
    output bb3_pkg::slot_t                                 job_slot,
    output logic [$clog2(MAX_WIDTH)-1:0]                   job_col,
    output logic                                           wr_en,
    output logic [bb3_pkg::SLOT_BITS+$clog2(MAX_WIDTH)-1:0] wr_addr,
    output bb3_pkg::pixel_t                                wr_data
);
    import bb3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_RESET  = (FRAME_WIDTH_DEFAULT > MAX_WIDTH) ? MAX_WIDTH
                                                                   : FRAME_WIDTH_DEFAULT;
    localparam int HEIGHT_RESET = (FRAME_HEIGHT_DEFAULT > MAX_HEIGHT) ? MAX_HEIGHT
                                                                     : FRAME_HEIGHT_DEFAULT;

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic [HW-1:0] in_row_reg,  in_row_upd;
    logic [CW-1:0] in_col_reg,  in_col_upd;
    slot_t         in_slot_reg, in_slot_upd;
    logic [HW-1:0] out_row_reg, out_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    slot_t         out_slot_reg, out_slot_next;
    logic          ahead_reg,   ahead_upd, ahead_next;

    logic [WW-1:0] cfg_width;
    logic [HW-1:0] cfg_height;
    logic          accept;
    logic          is_pixel;
    logic          in_last_col;
    logic          in_last_row;
    logic          overrun;
    logic          take_pixel;
    logic [HW-1:0] out_row_plus;
    logic [WW-1:0] out_col_plus;
    logic          bot_ok;
    logic          right_ok;
    logic [HW-1:0] need_row;
    logic [WW-1:0] need_col;
    logic          ready;

    // Clamp written sizes into 1..MAX
    assign cfg_width  = (cfg_data == '0) ? WW'(1)
                      : ((32'(cfg_data) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_data));
    assign cfg_height = (cfg_data == '0) ? HW'(1)
                      : ((32'(cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_data));

    // Accept while the job queue has room
    assign s_axis_tready = !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pixel      = (s_axis_tuser == REQ_PIXEL);

    // Classify the input position; drop a pixel that would overrun an older frame
    assign in_last_col = ((WW'(in_col_reg) + WW'(1)) == width_reg);
    assign in_last_row = ((in_row_reg + HW'(1)) == height_reg);
    assign overrun     = ahead_reg && in_last_row && in_last_col;
    assign take_pixel  = accept && is_pixel && !overrun;

    // Store the pixel in the line memory
    assign wr_en   = take_pixel;
    assign wr_addr = {in_slot_reg, in_col_reg};
    assign wr_data = s_axis_tdata;

    // Advance the input position
    always_comb
    begin
        in_col_upd  = in_col_reg;
        in_row_upd  = in_row_reg;
        in_slot_upd = in_slot_reg;
        ahead_upd   = ahead_reg;
        if (take_pixel)
        begin
            if (in_last_col)
            begin
                in_col_upd  = '0;
                in_slot_upd = in_slot_reg + slot_t'(1);
                if (in_last_row)
                begin
                    in_row_upd = '0;
                    ahead_upd  = 1'b1;
                end
                else
                begin
                    in_row_upd = in_row_reg + HW'(1);
                end
            end
            else
            begin
                in_col_upd = in_col_reg + CW'(1);
            end
        end
    end

    // Decide whether the next result has its whole neighborhood
    assign out_row_plus = out_row_reg + HW'(1);
    assign out_col_plus = WW'(out_col_reg) + WW'(1);
    assign bot_ok       = (out_row_plus < height_reg);
    assign right_ok     = (out_col_plus < width_reg);
    assign need_row     = bot_ok ? out_row_plus : (height_reg - HW'(1));
    assign need_col     = right_ok ? out_col_plus : (width_reg - WW'(1));
    assign ready        = ahead_upd || (in_row_upd > need_row)
                       || ((in_row_upd == need_row) && (WW'(in_col_upd) > need_col));

    // Hand the job to the back end
    assign job_push           = accept && ready;
    assign job_flags.top_ok   = (out_row_reg != '0);
    assign job_flags.bot_ok   = bot_ok;
    assign job_flags.left_ok  = (out_col_reg != '0);
    assign job_flags.right_ok = right_ok;
    assign job_flags.last     = !bot_ok && !right_ok;
    assign job_slot           = out_slot_reg;
    assign job_col            = out_col_reg;

    // Advance the output position
    always_comb
    begin
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_slot_next = out_slot_reg;
        ahead_next    = ahead_upd;
        if (ready)
        begin
            if (!right_ok)
            begin
                out_col_next  = '0;
                out_slot_next = out_slot_reg + slot_t'(1);
                if (!bot_ok)
                begin
                    out_row_next = '0;
                    ahead_next   = 1'b0;
                end
                else
                begin
                    out_row_next = out_row_plus;
                end
            end
            else
            begin
                out_col_next = CW'(out_col_plus);
            end
        end
    end

    // Hold sizes and positions; a register write restarts the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WW'(WIDTH_RESET);
            height_reg   <= HW'(HEIGHT_RESET);
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            ahead_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_width;
                REG_FRAME_HEIGHT: height_reg <= cfg_height;
                default: ;
            endcase
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            ahead_reg    <= 1'b0;
        end
        else if (accept)
        begin
            in_row_reg   <= in_row_upd;
            in_col_reg   <= in_col_upd;
            in_slot_reg  <= in_slot_upd;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            ahead_reg    <= ahead_next;
        end
    end

endmodule

// ----- rtl/bb3_back.sv -----
`timescale 1ns / 1ps

module bb3_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           wr_en,
    input  logic [bb3_pkg::SLOT_BITS+$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  bb3_pkg::pixel_t                                wr_data,
    input  logic                                           job_valid,
    input  bb3_pkg::job_flags_t                            job_flags,
    input  bb3_pkg::slot_t                                 job_slot,
    input  logic [$clog2(MAX_WIDTH)-1:0]                   job_col,
    output logic                                           job_pop,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    output bb3_pkg::pixel_t                                m_axis_tdata,
    output logic                                           m_axis_tlast
);
    import bb3_pkg::*;

    localparam int CW          = $clog2(MAX_WIDTH);
    localparam int AW          = SLOT_BITS + CW;
    localparam int DEPTH       = 1 << AW;
    localparam int SUM_BITS    = 12;
    localparam int COUNT_BITS  = 4;
    localparam int NUM_BITS    = 13;
    localparam int RECIP_BITS  = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int PROD_BITS   = NUM_BITS + RECIP_BITS;

    // ceil(2^18 / (2*count)); exact quotient for every numerator below 2^13
    function automatic logic [RECIP_BITS-1:0] recip_of(input logic [COUNT_BITS-1:0] count);
        logic [RECIP_BITS-1:0] r;
        begin
            case (count)
                4'd1:    r = 18'd131072;
                4'd2:    r = 18'd65536;
                4'd3:    r = 18'd43691;
                4'd4:    r = 18'd32768;
                4'd5:    r = 18'd26215;
                4'd6:    r = 18'd21846;
                4'd7:    r = 18'd18725;
                4'd8:    r = 18'd16384;
                4'd9:    r = 18'd14564;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Rounded mean: floor((2*sum+count)/(2*count))
    function automatic logic [7:0] mean_of(input logic [SUM_BITS-1:0]   sum,
                                           input logic [COUNT_BITS-1:0] count,
                                           input logic [RECIP_BITS-1:0] recip);
        logic [NUM_BITS-1:0]  num;
        logic [PROD_BITS-1:0] prod;
        begin
            num  = {sum, 1'b0} + NUM_BITS'(count);
            prod = PROD_BITS'(num) * PROD_BITS'(recip);
            return prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    endfunction

    pixel_t                mem [DEPTH];

    back_state_t           state_reg, state_next;
    job_flags_t            flags_reg;
    slot_t                 slot_reg;
    logic [CW-1:0]         col_reg;
    logic [1:0]            tap_row_reg;
    logic [1:0]            tap_col_reg;
    logic                  rd_pend_reg;
    logic                  rd_use_reg;
    pixel_t                rd_data_reg;
    logic [SUM_BITS-1:0]   sum_red_reg;
    logic [SUM_BITS-1:0]   sum_green_reg;
    logic [SUM_BITS-1:0]   sum_blue_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  out_valid_reg;
    pixel_t                out_data_reg;
    logic                  out_last_reg;

    logic                  rd_en;
    logic                  last_tap;
    logic                  load_out;
    logic                  row_ok;
    logic                  col_ok;
    logic                  tap_use;
    slot_t                 rd_slot;
    logic [CW+1:0]         rd_col_wide;
    logic [AW-1:0]         rd_addr;
    logic [RECIP_BITS-1:0] recip;
    pixel_t                mean;

    // Select the tap address; taps outside the frame are read but not summed
    assign rd_slot     = slot_t'(slot_reg + slot_t'(tap_row_reg) - slot_t'(1));
    assign rd_col_wide = (CW+2)'(col_reg) + (CW+2)'(tap_col_reg) - (CW+2)'(1);
    assign rd_addr     = {rd_slot, rd_col_wide[CW-1:0]};
    assign row_ok      = (tap_row_reg == 2'd0) ? flags_reg.top_ok
                       : ((tap_row_reg == 2'd2) ? flags_reg.bot_ok : 1'b1);
    assign col_ok      = (tap_col_reg == 2'd0) ? flags_reg.left_ok
                       : ((tap_col_reg == 2'd2) ? flags_reg.right_ok : 1'b1);
    assign tap_use     = row_ok && col_ok;
    assign last_tap    = (tap_row_reg == 2'd2) && (tap_col_reg == 2'd2);

    // Sequence one job: pop, nine reads, drain, load the result
    always_comb
    begin
        state_next = state_reg;
        job_pop    = 1'b0;
        rd_en      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                rd_en = 1'b1;
                if (last_tap)
                begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                state_next = BK_FINISH;
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Hold the state, tap counters and read tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            tap_row_reg   <= '0;
            tap_col_reg   <= '0;
            rd_pend_reg   <= 1'b0;
            rd_use_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_en;
            rd_use_reg  <= tap_use;
            if (job_pop)
            begin
                tap_row_reg <= '0;
                tap_col_reg <= '0;
            end
            else if (rd_en)
            begin
                if (tap_col_reg == 2'd2)
                begin
                    tap_col_reg <= '0;
                    tap_row_reg <= tap_row_reg + 2'd1;
                end
                else
                begin
                    tap_col_reg <= tap_col_reg + 2'd1;
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Latch the job and accumulate the taps that lie inside the frame
    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            flags_reg     <= job_flags;
            slot_reg      <= job_slot;
            col_reg       <= job_col;
            sum_red_reg   <= '0;
            sum_green_reg <= '0;
            sum_blue_reg  <= '0;
            count_reg     <= '0;
        end
        else if (rd_pend_reg && rd_use_reg)
        begin
            sum_red_reg   <= sum_red_reg   + SUM_BITS'(rd_data_reg.red);
            sum_green_reg <= sum_green_reg + SUM_BITS'(rd_data_reg.green);
            sum_blue_reg  <= sum_blue_reg  + SUM_BITS'(rd_data_reg.blue);
            count_reg     <= count_reg + COUNT_BITS'(1);
        end
    end

    // Line memory: written by the front, read here one tap a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Divide by the tap count through a reciprocal multiply
    assign recip      = recip_of(count_reg);
    assign mean.red   = mean_of(sum_red_reg,   count_reg, recip);
    assign mean.green = mean_of(sum_green_reg, count_reg, recip);
    assign mean.blue  = mean_of(sum_blue_reg,  count_reg, recip);

    // Hold the result until the sink takes it
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= mean;
            out_last_reg <= flags_reg.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- rtl/box_blur_3x3_clipped_core.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tdata: in_red, in_green, in_blue; tuser: req_type
// m_axis    out  tdata: out_red, out_green, out_blue; tlast: frame_end
// cfg       in   cfg_index 0 frame_width, 1 frame_height; cfg_data 11 bits
//
// The front takes one item per cycle while the two-entry job queue has room.
// In the back end each result takes one pop, nine taps through the single read
// port of the line memory, one drain, and one multiply into the output register;
// the back end finishes one result before it pops the next job.
// Reset clears control state only; the line memory is not cleared and needs no
// clearing pass. A stalled sink holds the back end, which then fills the queue
// and drops s_axis_tready.

`include "assert_macros.svh"

module box_blur_3x3_clipped_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  bb3_pkg::pixel_t              s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                         s_axis_tuser,   // req_type
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output bb3_pkg::pixel_t              m_axis_tdata,   // out_red, out_green, out_blue
    output logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bb3_pkg::CFG_BITS-1:0] cfg_data
);
    import bb3_pkg::*;

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int AW       = SLOT_BITS + CW;
    localparam int JOB_BITS = $bits(job_flags_t) + SLOT_BITS + CW;

    logic                job_push;
    job_flags_t          job_flags;
    slot_t               job_slot;
    logic [CW-1:0]       job_col;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    pixel_t              wr_data;
    logic [JOB_BITS-1:0] q_in;
    logic [JOB_BITS-1:0] q_out;
    logic                q_full;
    logic                q_empty;
    logic                job_pop;
    job_flags_t          hd_flags;
    slot_t               hd_slot;
    logic [CW-1:0]       hd_col;

    // Front: accept items, store pixels, issue jobs
    bb3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .queue_full    (q_full),
        .job_push      (job_push),
        .job_flags     (job_flags),
        .job_slot      (job_slot),
        .job_col       (job_col),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    // Queue jobs between front and back
    assign q_in = {job_flags, job_slot, job_col};

    bb3_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (q_in),
        .pop       (job_pop),
        .head_data (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {hd_flags, hd_slot, hd_col} = q_out;

    // Back: gather the neighborhood and produce the mean
    bb3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .job_valid     (!q_empty),
        .job_flags     (hd_flags),
        .job_slot      (hd_slot),
        .job_col       (hd_col),
        .job_pop       (job_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Queue occupancy checks across front and back
    `BB3_ASSERT_IMPLY(a_push_has_room, clk, rst_n, job_push, !q_full, "job pushed into full queue")
    `BB3_ASSERT_IMPLY(a_pop_has_job, clk, rst_n, job_pop, !q_empty, "job popped from empty queue")
    `BB3_ASSERT_NEXT(a_push_fills, clk, rst_n, job_push && !job_pop, !q_empty, "pushed job lost")
    `BB3_ASSERT_NEVER(a_full_empty, clk, rst_n, q_full && q_empty, "queue both full and empty")

endmodule

// ----- tb/sv/blur_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams and the register port, predicts every blurred pixel
// and compares it with what leaves the block.
module blur_checker #(
    parameter int LINE_MAX = 1024,
    parameter int ROWS_MAX = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    input  logic                         s_axis_tready,
    input  bb3_pkg::pixel_t              s_axis_tdata,   // in_red, in_green, in_blue
    input  logic                         s_axis_tuser,   // req_type
    input  logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    input  bb3_pkg::pixel_t              m_axis_tdata,   // out_red, out_green, out_blue
    input  logic                         m_axis_tlast,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bb3_pkg::CFG_BITS-1:0] cfg_data,
    output int                           fail_count,
    output int                           expected_left,
    output int                           results_owed
);

    import bb3_pkg::*;

    typedef struct packed {
        pixel_t px;
        logic   last;
    } blur_result_t;

    // Four rows of pixels, used as a ring by the input and output positions
    pixel_t              line_mem [4][LINE_MAX];
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    int                  in_row;
    int                  in_col;
    int                  out_row;
    int                  out_col;
    logic [1:0]          in_slot;
    logic [1:0]          out_slot;
    bit                  input_ahead;
    blur_result_t        blurred_q [$];

    function automatic int clamp_dim(logic [CFG_BITS-1:0] v, int lim);
        if (v == 0)
            return 1;
        if (int'(v) > lim)
            return lim;
        return int'(v);
    endfunction

    function automatic void restart_stream();
        in_row      = 0;
        in_col      = 0;
        out_row     = 0;
        out_col     = 0;
        in_slot     = 2'd0;
        out_slot    = 2'd0;
        input_ahead = 1'b0;
    endfunction

    // Absorb one item and queue the blurred pixel it releases, if any
    function automatic void predict_blur(req_t kind, pixel_t px);
        int           w;
        int           h;
        int           need_row;
        int           need_col;
        int           r;
        int           c;
        int           dr;
        int           dc;
        int           taps;
        int           sum_r;
        int           sum_g;
        int           sum_b;
        logic [1:0]   tap_slot;
        blur_result_t res;

        w = clamp_dim(width_reg, LINE_MAX);
        h = clamp_dim(height_reg, ROWS_MAX);

        // Store the pixel; drop it if it would close a frame the output has not reached
        if (kind == REQ_PIXEL && !(input_ahead && in_row == h - 1 && in_col == w - 1)
            && in_col < LINE_MAX)
        begin
            line_mem[in_slot][in_col] = px;
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_slot++;
                in_row++;
                if (in_row >= h)
                begin
                    in_row      = 0;
                    input_ahead = 1'b1;
                end
            end
        end

        // Release the next result only once its whole neighborhood is in
        need_row = (out_row + 1 < h) ? out_row + 1 : h - 1;
        need_col = (out_col + 1 < w) ? out_col + 1 : w - 1;
        if (!(input_ahead || in_row > need_row || (in_row == need_row && in_col > need_col)))
            return;

        // Average the neighbors that lie inside the frame
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        taps  = 0;
        for (dr = -1; dr <= 1; dr++)
        begin
            r = out_row + dr;
            if (r >= 0 && r < h)
            begin
                tap_slot = 2'((int'(out_slot) + 4 + dr) % 4);
                for (dc = -1; dc <= 1; dc++)
                begin
                    c = out_col + dc;
                    if (c >= 0 && c < w && c < LINE_MAX)
                    begin
                        sum_r += line_mem[tap_slot][c].red;
                        sum_g += line_mem[tap_slot][c].green;
                        sum_b += line_mem[tap_slot][c].blue;
                        taps++;
                    end
                end
            end
        end
        res.px.red   = 8'((2 * sum_r + taps) / (2 * taps));
        res.px.green = 8'((2 * sum_g + taps) / (2 * taps));
        res.px.blue  = 8'((2 * sum_b + taps) / (2 * taps));
        res.last     = (out_row == h - 1 && out_col == w - 1);
        blurred_q.push_back(res);

        // Advance the output position
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_slot++;
            out_row++;
            if (out_row >= h)
            begin
                out_row     = 0;
                input_ahead = 1'b0;
            end
        end
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        blur_result_t want;
        int           w;
        int           h;

        if (!rst_n)
        begin
            fail_count = 0;
            width_reg  = CFG_BITS'(FRAME_WIDTH_DEFAULT);
            height_reg = CFG_BITS'(FRAME_HEIGHT_DEFAULT);
            restart_stream();
            blurred_q.delete();
        end
        else
        begin
            // Compare each outgoing item with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (blurred_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result %h (last %b) with nothing expected",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    want = blurred_q.pop_front();
                    check_field("red", want.px.red, m_axis_tdata.red);
                    check_field("green", want.px.green, m_axis_tdata.green);
                    check_field("blue", want.px.blue, m_axis_tdata.blue);
                    check_field("frame_end", want.last, m_axis_tlast);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                predict_blur(req_t'(s_axis_tuser), s_axis_tdata);

            // A register write restarts the stream and drops what was owed
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                restart_stream();
            end
        end

        // Publish how much is queued and how many stored pixels still await a result
        w             = clamp_dim(width_reg, LINE_MAX);
        h             = clamp_dim(height_reg, ROWS_MAX);
        expected_left = blurred_q.size();
        results_owed  = (input_ahead ? w * h : 0) + in_row * w + in_col
                        - out_row * w - out_col;
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    import bb3_pkg::*;

    localparam int LINE_MAX     = 1024;
    localparam int ROWS_MAX     = 1024;
    localparam int IDLE_LIMIT   = 4000;
    localparam int CFG_SETTLE   = 60;
    localparam int END_SETTLE   = 100;
    localparam int RANDOM_ITEMS = 1300;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    pixel_t              s_axis_tdata;   // in_red, in_green, in_blue
    logic                s_axis_tuser;   // req_type
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    pixel_t              m_axis_tdata;   // out_red, out_green, out_blue
    logic                m_axis_tlast;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    int fail_count;
    int expected_left;
    int results_owed;
    int items_sent;
    int idle_cycles;
    int rx_hold;
    bit calm_tx;
    bit calm_rx;

    box_blur_3x3_clipped_core #(
        .MAX_WIDTH  (LINE_MAX),
        .MAX_HEIGHT (ROWS_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    blur_checker #(
        .LINE_MAX (LINE_MAX),
        .ROWS_MAX (ROWS_MAX)
    ) u_blur_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .expected_left (expected_left),
        .results_owed  (results_owed)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    // Stall the sink: mostly short stalls, a few long ones, and calm stretches
    initial
    begin
        m_axis_tready = 1'b0;
        rx_hold       = 0;
        calm_rx       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
                rx_hold--;
            else
            begin
                if ($urandom_range(0, 99) == 0)
                    calm_rx = !calm_rx;
                if (!calm_rx && $urandom_range(0, 3) == 0)
                    rx_hold = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(1, 4);
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 79) == 0)
            calm_tx = !calm_tx;
        if (calm_tx || $urandom_range(0, 2) != 0)
            return 0;
        return ($urandom_range(0, 14) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        case ($urandom_range(0, 7))
            0: px = '0;
            1: px = '1;
            default:
            begin
                px.red   = 8'($urandom_range(0, 255));
                px.green = 8'($urandom_range(0, 255));
                px.blue  = 8'($urandom_range(0, 255));
            end
        endcase
        return px;
    endfunction

    // Step to the next falling edge, where the sender may drive
    task automatic next_slot();
        @(negedge clk);
    endtask

    // Called at a falling edge: optional gap, then present the item until taken
    task automatic put_item(req_t kind, pixel_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic send(req_t kind, pixel_t px);
        next_slot();
        put_item(kind, px);
    endtask

    // Drop valid and wait until every predicted result has left the block
    task automatic hold_off();
        next_slot();
        s_axis_tvalid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
    endtask

    // Push flushes until the stored pixels have all produced their results, at most as many as were owed at the start
    task automatic flush_backlog();
        int cap;
        int done;
        cap  = -1;
        done = 0;
        forever
        begin
            next_slot();
            if (cap < 0)
                cap = results_owed;
            if (results_owed == 0 || done >= cap)
            begin
                s_axis_tvalid <= 1'b0;
                break;
            end
            put_item(REQ_FLUSH, random_pixel());
            done++;
        end
    endtask

    // Write both size registers once the block has gone quiet
    task automatic write_size(logic [CFG_BITS-1:0] w, logic [CFG_BITS-1:0] h);
        hold_off();
        repeat (CFG_SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixels(int n, int flush_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < flush_pct)
                send(REQ_FLUSH, random_pixel());
            send(REQ_PIXEL, random_pixel());
            if ($urandom_range(0, 299) == 0)
                hold_off();
        end
    endtask

    initial
    begin
        pixel_t px;
        int     w;
        int     h;
        int     area;
        int     flush_pct;
        int     target;
        bit     big;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_PIXEL;
        cfg_we        = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        items_sent    = 0;
        calm_tx       = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 3x3 frame: flush with nothing ready, then corners, edges and center
        write_size(3, 3);
        send(REQ_FLUSH, '0);
        for (int i = 0; i < 9; i++)
        begin
            px.red   = (i % 2 == 1) ? 8'hFF : 8'h00;
            px.green = (i < 3) ? 8'h00 : 8'hFF;
            px.blue  = (i == 4) ? 8'hFF : 8'h00;
            send(REQ_PIXEL, px);
            if (i == 5)
                hold_off();
        end
        flush_backlog();

        // Zero sizes act as a single pixel
        write_size(0, 0);
        send(REQ_PIXEL, '1);
        send(REQ_PIXEL, '0);

        // One column, two rows; leave the second frame unfinished so the write drops it
        write_size(1, 2);
        send(REQ_PIXEL, random_pixel());
        send(REQ_PIXEL, random_pixel());
        send(REQ_PIXEL, random_pixel());
        send(REQ_FLUSH, random_pixel());

        // Random phases: mostly small frames back to back, a few at the size limits
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            big = 1'b0;
            case ($urandom_range(0, 11))
                0:
                begin
                    big = 1'b1;
                    case ($urandom_range(0, 3))
                        0: begin w = 2047; h = 1;    end
                        1: begin w = 1024; h = 1;    end
                        2: begin w = 1;    h = 2047; end
                        default: begin w = 1; h = 1024; end
                    endcase
                end
                1:
                begin
                    w = $urandom_range(0, 1);
                    h = $urandom_range(0, 6);
                end
                2:
                begin
                    w = $urandom_range(1, 12);
                    h = $urandom_range(0, 1);
                end
                default:
                begin
                    w = $urandom_range(2, 12);
                    h = $urandom_range(2, 7);
                end
            endcase
            write_size(CFG_BITS'(w), CFG_BITS'(h));
            flush_pct = $urandom_range(0, 25);
            if (big)
                send_pixels($urandom_range(20, 70), flush_pct);
            else
            begin
                area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                send_pixels(area * $urandom_range(1, 3), flush_pct);
                if (area > 1 && $urandom_range(0, 2) == 0)
                    send_pixels($urandom_range(1, area - 1), flush_pct);
            end
            if ($urandom_range(0, 3) != 0)
                flush_backlog();
        end

        // Drain and give the verdict
        hold_off();
        repeat (END_SETTLE) @(negedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
